// ===== rtl/core/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants, codes and types of the swap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

  // Geometry of the slot store
  localparam int SLOT_COUNT       = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  // Field widths
  localparam int SLOT_W   = 10;
  localparam int SECTOR_W = 13;
  localparam int LIMIT_W  = 11;
  localparam int STATUS_W = 2;

  // Bitmap organization: one memory row holds WORD_W slot bits
  localparam int WORD_W = (SLOT_COUNT < 32) ? SLOT_COUNT : 32;
  localparam int ROWS   = SLOT_COUNT / WORD_W;
  localparam int BIT_W  = (WORD_W > 1) ? $clog2(WORD_W) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Sector counter within one run
  localparam int CNT_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SECTORS_PER_SLOT - 1);

  // Reset value of the slot limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef enum logic [0:0] {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_FREE  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_POST
  } ctrl_state_t;

  // Decision handed from the map controller to the result sequencer
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssa_if.sv =====
// ----------------------------------------------------------------------------
// ssa_if
// Valid/ready channels of the swap slot allocator: request, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssa_req_if import ssa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

interface ssa_res_if import ssa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [SECTOR_W-1:0] sector;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output slot, output sector, output status, output last,
                  input ready);
  modport sink   (input valid, input slot, input sector, input status, input last,
                  output ready);
endinterface

interface ssa_cfg_if import ssa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] slot_limit;

  modport source (output valid, output slot_limit, input ready);
  modport sink   (input valid, input slot_limit, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ssa_ram.sv =====
// ----------------------------------------------------------------------------
// ssa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssa_ctrl
// Bitmap controller: picks the row, reads it, updates the slot bit, writes
// the row back and hands the decision to the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_ctrl import ssa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ssa_req_if.sink            req,
  input  logic [LIMIT_W-1:0] eff_limit,
  // bitmap memory
  output logic               ram_we,
  output logic [ROW_W-1:0]   ram_waddr,
  output logic [WORD_W-1:0]  ram_wdata,
  output logic [ROW_W-1:0]   ram_raddr,
  input  logic [WORD_W-1:0]  ram_rdata,
  // decision to the sequencer
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  ctrl_state_t state, state_next;

  req_type_t         req_type_q;
  logic [SLOT_W-1:0] idx_q;
  logic [ROW_W-1:0]  row_q;
  status_t           pre_status_q;
  job_t              job_q;

  // Per-row summary: row written at least once, row has no free bit
  logic [ROWS-1:0] row_valid;
  logic [ROWS-1:0] row_full;

  logic              req_fire;
  logic [LIMIT_W:0]  lim_rows;
  logic [ROWS-1:0]   cand;
  logic              alloc_found;
  logic [ROW_W-1:0]  alloc_row;
  logic              idx_in_range;
  status_t           pre_status;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] lim_mask;
  logic [WORD_W-1:0] free_bits;
  logic              free_any;
  logic [BIT_W-1:0]  free_bit;
  logic [BIT_W-1:0]  rel_bit;
  logic [WORD_W-1:0] new_word;
  logic              write_ok;
  job_t              mod_job;

  assign req_fire = req.valid && req.ready;

  // Row search for an allocate: lowest row below the limit that is not full
  always_comb begin
    lim_rows = ((LIMIT_W + 1)'(eff_limit) + (LIMIT_W + 1)'(WORD_W - 1)) >> BIT_W;
    for (int r = 0; r < ROWS; r++) begin
      cand[r] = !row_full[r] && ((LIMIT_W + 1)'(r) < lim_rows);
    end
    alloc_found = |cand;
    alloc_row   = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (cand[r]) begin
        alloc_row = ROW_W'(r);
      end
    end
  end

  // Early checks at accept time
  always_comb begin
    idx_in_range = LIMIT_W'(req.slot_index) < eff_limit;
    pre_status   = ST_OK;
    if (req.req_type == REQ_ALLOC) begin
      if (!alloc_found) begin
        pre_status = ST_FULL;
      end
    end else if (!idx_in_range) begin
      pre_status = ST_RANGE;
    end
  end

  // Row read is issued in the accept cycle; data is back in S_MOD
  assign ram_raddr = (req.req_type == REQ_ALLOC) ? alloc_row
                                                 : req.slot_index[SLOT_W-1:BIT_W];

  // Read-modify of the fetched row
  always_comb begin
    word = row_valid[row_q] ? ram_rdata : '0;
    for (int b = 0; b < WORD_W; b++) begin
      lim_mask[b] = LIMIT_W'({row_q, BIT_W'(b)}) < eff_limit;
    end
    free_bits = ~word & lim_mask;
    free_any  = |free_bits;
    free_bit  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_bit = BIT_W'(b);
      end
    end
    rel_bit        = idx_q[BIT_W-1:0];
    new_word       = word;
    write_ok       = 1'b0;
    mod_job.slot   = idx_q;
    mod_job.status = ST_OK;
    if (pre_status_q != ST_OK) begin
      mod_job.status = pre_status_q;
      if (req_type_q == REQ_ALLOC) begin
        mod_job.slot = '0;
      end
    end else if (req_type_q == REQ_ALLOC) begin
      if (!free_any) begin
        // free bits of the boundary row all lie beyond the limit
        mod_job.status = ST_FULL;
        mod_job.slot   = '0;
      end else begin
        new_word[free_bit] = 1'b1;
        write_ok           = 1'b1;
        mod_job.slot       = {row_q, free_bit};
      end
    end else begin
      if (!word[rel_bit]) begin
        mod_job.status = ST_FREE;
      end else begin
        new_word[rel_bit] = 1'b0;
        write_ok          = 1'b1;
      end
    end
  end

  // Write-back in S_MOD; the FSM passes through S_POST before the next read is issued
  assign ram_we    = (state == S_MOD) && write_ok;
  assign ram_waddr = row_q;
  assign ram_wdata = new_word;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        state_next = S_POST;
      end
      S_POST: begin
        if (job_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // FSM outputs
  always_comb begin
    req.ready = 1'b0;
    job_valid = 1'b0;
    unique case (state)
      S_IDLE:  req.ready = 1'b1;
      S_MOD:   ;
      S_POST:  job_valid = 1'b1;
      default: ;
    endcase
  end

  assign job = job_q;

  // Control state and row summaries
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      row_full  <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        row_valid[row_q] <= 1'b1;
        row_full[row_q]  <= &new_word;
      end
    end
  end

  // Request and decision registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_type_q   <= req_type_t'(req.req_type);
      idx_q        <= req.slot_index;
      row_q        <= ram_raddr;
      pre_status_q <= pre_status;
    end
    if (state == S_MOD) begin
      job_q <= mod_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssa_emit.sv =====
// ----------------------------------------------------------------------------
// ssa_emit
// Result sequencer: turns one decision into its sector run or error result,
// through an output register on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_emit import ssa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  ssa_res_if.source res
);

  logic                out_valid;
  logic [SLOT_W-1:0]   out_slot;
  logic [SECTOR_W-1:0] out_sector;
  status_t             out_status;
  logic                out_last;
  logic [CNT_W-1:0]    cnt;

  logic                res_fire;
  logic                load;
  logic [CNT_W-1:0]    cnt_next;
  logic [SECTOR_W-1:0] base_sector;

  assign res_fire    = out_valid && res.ready;
  assign job_ready   = !out_valid || (res.ready && out_last);
  assign load        = job_valid && job_ready;
  assign cnt_next    = cnt + CNT_W'(1);
  assign base_sector = SECTOR_W'(32'(job.slot) * SECTORS_PER_SLOT);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res_fire && out_last) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload and sector counter
  always_ff @(posedge clk) begin
    if (load) begin
      out_slot   <= job.slot;
      out_status <= job.status;
      cnt        <= '0;
      if (job.status == ST_OK) begin
        out_sector <= base_sector;
        out_last   <= (SECTORS_PER_SLOT == 1);
      end else begin
        out_sector <= '0;
        out_last   <= 1'b1;
      end
    end else if (res_fire && !out_last) begin
      cnt        <= cnt_next;
      out_sector <= out_sector + SECTOR_W'(1);
      out_last   <= (cnt_next == LAST_CNT);
    end
  end

  assign res.valid  = out_valid;
  assign res.slot   = out_slot;
  assign res.sector = out_sector;
  assign res.status = out_status;
  assign res.last   = out_last;

endmodule

`default_nettype wire

// ===== rtl/core/swap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// swap_slot_allocator
// First-fit bitmap allocator for swap slots with per-sector result runs.
// ----------------------------------------------------------------------------
// Usage:
//   req: valid/ready request channel. req_type 0 allocates the lowest free
//     slot below the limit, 1 releases slot_index.
//   res: valid/ready result channel. A good request yields SECTORS_PER_SLOT
//     results (sector = slot * SECTORS_PER_SLOT + offset), last on the final
//     one; an error yields one result with its status, sector 0 and last set.
//   cfg: valid/ready write of slot_limit; always ready. Write it only while
//     the block is idle.
// Flow: the bitmap controller steps each request through accept with row
//   read, modify and write-back, and handoff from the decision register to
//   the sequencer's output register; it can work on the next request while
//   the sequencer still emits. Good requests are paced by the result
//   channel, which carries SECTORS_PER_SLOT results for each of them; error
//   requests are paced by the controller.
// Reset: all slots free, slot_limit 1024; per-row valid flags stand in for a
//   cleared memory, so no clearing pass is needed.
// Stall: a held result freezes the sequencer; the controller then waits in
//   handoff with req.ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_slot_allocator import ssa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ssa_req_if.sink    req,
  ssa_res_if.source  res,
  ssa_cfg_if.sink    cfg
);

  logic [LIMIT_W-1:0] slot_limit;
  logic [LIMIT_W-1:0] eff_limit;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic job_valid;
  logic job_ready;
  job_t job;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      slot_limit <= cfg.slot_limit;
    end
  end

  // Limit saturates at the store size
  assign eff_limit = (slot_limit > LIMIT_W'(SLOT_COUNT)) ? LIMIT_W'(SLOT_COUNT) : slot_limit;

  // Slot bitmap storage
  ssa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .eff_limit (eff_limit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  ssa_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res       (res)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ssa_checker.sv =====
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks on the result stream of the swap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_checker import ssa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [SLOT_W-1:0]   res_slot,
  input logic [SECTOR_W-1:0] res_sector,
  input logic [STATUS_W-1:0] res_status,
  input logic                res_last
);

  logic [SECTOR_W-1:0] offset;

  assign offset = res_sector - SECTOR_W'(32'(res_slot) * SECTORS_PER_SLOT);

  // Stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_slot) && $stable(res_sector)
                                && $stable(res_status) && $stable(res_last))
    else $error("result changed while stalled");

  // Error results are single, sector zero
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != ST_OK) |-> res_last && (res_sector == '0))
    else $error("malformed error result");

  // A run continues in the next cycle with the next sector of the same slot
  a_run_next: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && (res_status == ST_OK) && !res_last
      |=> res_valid && (res_status == ST_OK) && (res_slot == $past(res_slot))
          && (res_sector == $past(res_sector) + SECTOR_W'(1)))
    else $error("sector run broken");

  // The final result of a run sits at the last sector of its slot
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_OK) && res_last |-> offset == SECTOR_W'(SECTORS_PER_SLOT - 1))
    else $error("run ends at wrong sector");

endmodule

bind swap_slot_allocator ssa_checker u_ssa_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_slot   (res.slot),
  .res_sector (res.sector),
  .res_status (res.status),
  .res_last   (res.last)
);

`default_nettype wire
